>>> src/interrupt_priority_entry_top_macros.svh
// assertion macros shared by the checker of interrupt_priority_entry_top
// expects clk and arst_n in the scope where a macro is used
`ifndef INTERRUPT_PRIORITY_ENTRY_TOP_MACROS_SVH
`define INTERRUPT_PRIORITY_ENTRY_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IPE_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define IPE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> src/ipe_pkg.sv
// shared types, constants and helpers of the interrupt priority entry block
// no dependencies
package ipe_pkg;

	localparam int LINE_COUNT_DEF = 16;
	localparam int PRIO_LINES     = 16;
	localparam int PRIO_WORDS     = 4;
	localparam int CODE_W         = 12;
	localparam int LINE_W         = 4;
	localparam int PRIO_W         = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;

	localparam logic [31:0] ENTRY_OFFSET = 32'h0000_0600;
	localparam int SR_BL_BIT = 28;
	localparam int SR_RB_BIT = 29;
	localparam int SR_MD_BIT = 30;
	localparam int SR_FD_BIT = 15;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VBR    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ENTRY
	} ipe_state_t;

	typedef logic [PRIO_WORDS-1:0][15:0] prio_words_t;

	typedef struct packed {
		logic              mode;
		logic [LINE_W-1:0] line;
		logic [CODE_W-1:0] event_in;
		logic [31:0]       cur_pc;
		logic [31:0]       cur_sr;
		logic [31:0]       cur_r15;
		logic              in_delay_slot;
	} ipe_req_t;

	typedef struct packed {
		logic              taken;
		logic [LINE_W-1:0] taken_line;
		logic [CODE_W-1:0] event_out;
		logic [31:0]       next_pc;
		logic [31:0]       next_sr;
		logic [31:0]       saved_pc;
		logic [31:0]       saved_sr;
		logic [31:0]       saved_r15;
	} ipe_rsp_t;

	// one scanned line handed to the selector
	typedef struct packed {
		logic              vld;
		logic [LINE_W-1:0] line;
		logic [PRIO_W-1:0] prio;
		logic [CODE_W-1:0] code;
	} ipe_cand_t;

	// running winner of a scan
	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] prio;
		logic [LINE_W-1:0] line;
		logic [CODE_W-1:0] code;
	} ipe_best_t;

	// 4-bit priority of a line below sixteen
	function automatic logic [PRIO_W-1:0] prio_of(input prio_words_t words,
			input logic [LINE_W-1:0] ln);
		logic [15:0] w;
		w = words[ln[3:2]];
		return w[{ln[1:0], 2'b00} +: PRIO_W];
	endfunction

endpackage

>>> src/ipe_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ipe_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/ipe_sel.sv
// priority selector: keeps the best pending line seen during a scan
// depends on ipe_pkg
module ipe_sel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  ipe_pkg::ipe_cand_t  cand,
	input  logic [3:0]          imask,
	output ipe_pkg::ipe_best_t  best
);
	import ipe_pkg::*;

	ipe_best_t best_q;
	logic      hit;

	// strictly greater keeps the lowest line on a tie
	assign hit = cand.vld && (cand.prio > imask) && (cand.code != '0) &&
		(!best_q.found || (cand.prio > best_q.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clr) begin
			best_q <= '0;
		end else if (hit) begin
			best_q.found <= 1'b1;
			best_q.prio  <= cand.prio;
			best_q.line  <= cand.line;
			best_q.code  <= cand.code;
		end
	end

	assign best = best_q;

endmodule

>>> src/interrupt_priority_entry_top.sv
// top level of the interrupt priority select and entry block
// depends on ipe_pkg, ipe_ram, ipe_sel
//
// channel   | signals                        | handshake
// ----------+--------------------------------+----------------------------------
// request   | start, busy, request           | taken when start && !busy
// result    | done, result                   | one-cycle strobe, no backpressure
// config    | cfg_we, cfg_idx, cfg_wdata     | written when cfg_we, no wait
//
// a raise request or a blocked check (delay slot or SR.BL) answers on the
// next cycle and the block is ready again at once
// a check that scans reads min(LINE_COUNT,16) lines: one pending-code ram
// read per line, a drain state for the last read to reach the selector, an
// entry state that clears the winning line
// reset clears the config registers, the fsm and the per-line valid bits, so
// every line reads as not pending with no clearing pass
// the result cannot be stalled; a new request may enter while done is high
module interrupt_priority_entry_top #(
	parameter int LINE_COUNT = ipe_pkg::LINE_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  ipe_pkg::ipe_req_t                  request,
	input  logic                               cfg_we,
	input  logic [ipe_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ipe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                               done,
	output ipe_pkg::ipe_rsp_t                  result
);
	import ipe_pkg::*;

	localparam int AW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	// only lines with a priority nibble can ever win
	localparam int SCAN_LINES = (LINE_COUNT < PRIO_LINES) ? LINE_COUNT : PRIO_LINES;
	localparam logic [AW-1:0] LAST_IDX = AW'(SCAN_LINES - 1);

	// config registers
	prio_words_t prio_q;
	logic [31:0] vbr_q;

	// control
	ipe_state_t state_q, state_d;
	logic [AW-1:0] idx_q;
	logic [LINE_COUNT-1:0] vld_q;
	logic accept, go_raise, go_block, go_scan, in_range;

	// captured check request
	ipe_req_t req_q;

	// read pipeline stage
	logic          scan_s1;
	logic          vld_s1;
	logic [AW-1:0] line_s1;

	// ram ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CODE_W-1:0] ram_wdata;
	logic [CODE_W-1:0] ram_rdata;

	ipe_cand_t cand;
	ipe_best_t best;

	// result register
	logic     done_q;
	ipe_rsp_t result_q;
	ipe_rsp_t result_d;

	assign accept   = start && !busy;
	assign go_raise = accept && !request.mode;
	assign go_block = accept && request.mode &&
		(request.in_delay_slot || request.cur_sr[SR_BL_BIT]);
	assign go_scan  = accept && request.mode &&
		!request.in_delay_slot && !request.cur_sr[SR_BL_BIT];
	// raises beyond the last line are dropped
	assign in_range = int'(request.line) < LINE_COUNT;

	// config writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= '0;
			vbr_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PRIO_A: prio_q[0] <= cfg_wdata[15:0];
				CFG_PRIO_B: prio_q[1] <= cfg_wdata[15:0];
				CFG_PRIO_C: prio_q[2] <= cfg_wdata[15:0];
				CFG_PRIO_D: prio_q[3] <= cfg_wdata[15:0];
				CFG_VBR:    vbr_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// fsm state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and busy
	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_ENTRY;
			ST_ENTRY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// scan address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (go_scan) begin
			idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// check request held for the entry cycle
	always_ff @(posedge clk) begin
		if (go_scan) begin
			req_q <= request;
		end
	end

	// per-line valid bits: a never-written line reads as not pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (go_raise && in_range) begin
			vld_q[AW'(request.line)] <= 1'b1;
		end
	end

	// write port: raise stores the code, entry clears the winner
	// the two never meet since no request is taken during a scan
	always_comb begin
		if ((state_q == ST_ENTRY) && best.found) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(best.line);
			ram_wdata = '0;
		end else begin
			ram_we    = go_raise && in_range;
			ram_waddr = AW'(request.line);
			ram_wdata = request.event_in;
		end
	end

	ipe_ram #(
		.WIDTH (CODE_W),
		.DEPTH (LINE_COUNT)
	) u_pending (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// stage that lines up with the registered ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		line_s1 <= idx_q;
		vld_s1  <= vld_q[idx_q];
	end

	assign cand.vld  = scan_s1;
	assign cand.line = LINE_W'(line_s1);
	assign cand.prio = prio_of(prio_q, LINE_W'(line_s1));
	assign cand.code = vld_s1 ? ram_rdata : '0;

	ipe_sel u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (go_scan),
		.cand   (cand),
		.imask  (req_q.cur_sr[7:4]),
		.best   (best)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go_raise || go_block || (state_q == ST_ENTRY);
		end
	end

	// next result payload: entry fields only when a line wins
	always_comb begin
		result_d = '0;
		if (state_q == ST_ENTRY) begin
			if (best.found) begin
				result_d.taken      = 1'b1;
				result_d.taken_line = best.line;
				result_d.event_out  = best.code;
				result_d.next_pc    = vbr_q + ENTRY_OFFSET;
				result_d.next_sr    = req_q.cur_sr;
				result_d.next_sr[SR_BL_BIT] = 1'b1;
				result_d.next_sr[SR_RB_BIT] = 1'b1;
				result_d.next_sr[SR_MD_BIT] = 1'b1;
				result_d.next_sr[SR_FD_BIT] = 1'b0;
				result_d.saved_pc   = req_q.cur_pc;
				result_d.saved_sr   = req_q.cur_sr;
				result_d.saved_r15  = req_q.cur_r15;
			end else begin
				result_d.next_pc = req_q.cur_pc;
				result_d.next_sr = req_q.cur_sr;
			end
		end else begin
			result_d.next_pc = request.cur_pc;
			result_d.next_sr = request.cur_sr;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go_raise || go_block || (state_q == ST_ENTRY)) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> src/ipe_checker.sv
// port-level checker for interrupt_priority_entry_top, bound to the top level
// depends on ipe_pkg and interrupt_priority_entry_top_macros.svh
`include "interrupt_priority_entry_top_macros.svh"

module ipe_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input ipe_pkg::ipe_req_t                  request,
	input logic                               done,
	input ipe_pkg::ipe_rsp_t                  result
);
	import ipe_pkg::*;

	logic quick_req;
	logic scan_req;

	assign quick_req = start && !busy && (!request.mode || request.in_delay_slot ||
		request.cur_sr[SR_BL_BIT]);
	assign scan_req  = start && !busy && request.mode && !request.in_delay_slot &&
		!request.cur_sr[SR_BL_BIT];

	`IPE_ASSERT_NEXT(a_quick_answer, quick_req, done && !result.taken,
		"raise or blocked check did not answer next cycle")

	`IPE_ASSERT_NEXT(a_scan_busy, scan_req, busy && !done,
		"scanning check did not hold busy")

	`IPE_ASSERT_NOW(a_not_taken_clean, done && !result.taken,
		result.taken_line == '0 && result.event_out == '0 && result.saved_pc == '0 &&
		result.saved_sr == '0 && result.saved_r15 == '0,
		"result without entry carries entry fields")

	`IPE_ASSERT_NOW(a_taken_sr, done && result.taken,
		result.next_sr[SR_BL_BIT] && result.next_sr[SR_RB_BIT] &&
		result.next_sr[SR_MD_BIT] && !result.next_sr[SR_FD_BIT] &&
		result.event_out != '0 && !result.saved_sr[SR_BL_BIT],
		"entry result with bad sr or empty event code")

endmodule

bind interrupt_priority_entry_top ipe_checker u_ipe_checker (.*);
